/* src/cron_expression_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// cron expression parser - assertion macros
// shared property templates, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CRON_EXPRESSION_PARSER_CORE_MACROS_SVH
`define CRON_EXPRESSION_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define CEP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cep: same-cycle check failed");

// next-cycle implication
`define CEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cep: next-cycle check failed");

`endif

/* src/cep_pkg.sv */
// ----------------------------------------------------------------------------
// cep_pkg
// types, character codes, field limits and name tables of the cron parser
// ----------------------------------------------------------------------------
package cep_pkg;

    localparam int NAME_BUF_LEN = 9;
    localparam int NUM_FIELDS   = 5;

    localparam logic [16:0] NUM_LIMIT = 17'd100000;

    localparam logic [2:0] FLD_DOM   = 3'd2;
    localparam logic [2:0] FLD_MONTH = 3'd3;
    localparam logic [2:0] FLD_DOW   = 3'd4;
    localparam logic [2:0] FLD_COUNT = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_UP_L  = 8'h4c;
    localparam logic [7:0] CH_LO_L  = 8'h6c;
    localparam logic [7:0] CH_UP_W  = 8'h57;
    localparam logic [7:0] CH_LO_W  = 8'h77;

    typedef enum logic [3:0] {
        PH_BETWEEN,
        PH_BASE,
        PH_NUM_A,
        PH_NAME_A,
        PH_AFTER_BASE,
        PH_END_START,
        PH_NUM_B,
        PH_NAME_B,
        PH_STEP_START,
        PH_STEP
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_WAIT_CHAR,
        ST_LAST,
        ST_WAIT_LAST,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic do_char;
        logic do_last;
        logic finish;
    } cep_cmd_t;

    typedef struct packed {
        logic exp_busy;
        logic out_busy;
        logic last;
    } cep_sts_t;

    typedef logic [NAME_BUF_LEN-1:0][7:0] name_buf_t;

    // words are right-justified: first letter in the highest used byte
    localparam logic [71:0] MONTH_WORDS [12] = '{
        72'("january"), 72'("february"), 72'("march"), 72'("april"),
        72'("may"), 72'("june"), 72'("july"), 72'("august"),
        72'("september"), 72'("october"), 72'("november"), 72'("december")};
    localparam logic [3:0] MONTH_LEN [12] = '{
        4'd7, 4'd8, 4'd5, 4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd9, 4'd7, 4'd8, 4'd8};
    localparam logic [71:0] DAY_WORDS [7] = '{
        72'("sunday"), 72'("monday"), 72'("tuesday"), 72'("wednesday"),
        72'("thursday"), 72'("friday"), 72'("saturday")};
    localparam logic [3:0] DAY_LEN [7] = '{
        4'd6, 4'd6, 4'd7, 4'd9, 4'd8, 4'd6, 4'd8};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'd32 : c;
    endfunction

    function automatic logic [6:0] field_lo(input logic [2:0] k);
        logic [6:0] v;
        case (k)
            FLD_DOM, FLD_MONTH: v = 7'd1;
            default:            v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] field_hi(input logic [2:0] k);
        logic [6:0] v;
        case (k)
            3'd0:      v = 7'd59;
            3'd1:      v = 7'd23;
            FLD_DOM:   v = 7'd31;
            FLD_MONTH: v = 7'd12;
            default:   v = 7'd7;
        endcase
        return v;
    endfunction

    // {hit, value}; letters are stored lower case
    function automatic logic [4:0] name_lookup(input name_buf_t letters,
                                               input logic [3:0] n,
                                               input logic is_month);
        logic [4:0]  res;
        logic        ok;
        logic [71:0] w;
        logic [3:0]  wl;
        int          pos;
        res = '0;
        if ((n >= 4'd3) && (32'(n) <= NAME_BUF_LEN)) begin
            for (int i = 0; i < 12; i++) begin
                if (is_month || (i < 7)) begin
                    w  = is_month ? MONTH_WORDS[i] : DAY_WORDS[i % 7];
                    wl = is_month ? MONTH_LEN[i] : DAY_LEN[i % 7];
                    ok = (n == 4'd3) || (n == wl);
                    for (int j = 0; j < NAME_BUF_LEN; j++) begin
                        pos = int'(wl) - 1 - j;
                        if (ok && (j < int'(n)) && (pos >= 0)) begin
                            if (letters[j] != w[pos*8 +: 8]) begin
                                ok = 1'b0;
                            end
                        end
                    end
                    if (ok && !res[4]) begin
                        res = {1'b1, is_month ? 4'(i + 1) : 4'(i)};
                    end
                end
            end
        end
        return res;
    endfunction

endpackage

/* src/cron_expression_parser_core.sv */
// ----------------------------------------------------------------------------
// cron_expression_parser_core
// five-field cron text in, one beat per character; field masks out per text
// ----------------------------------------------------------------------------
// Each input beat carries one character of a cron expression; tlast marks the
// final one. An ordinary character passes the idle, char and wait states. A
// piece that closes with a range adds one mask update when the step is 1, and
// one update per value set (up to 30) when the step is larger, since the range
// expander visits the stepped values one a cycle. The last character adds the
// last, wait and finish states to close the last field and load the result
// register, plus the expansion of that field's final piece. One result beat
// follows each tlast beat; tuser high means the text was rejected and all
// masks are zero. A new character is taken while an earlier result still
// waits on the master side; only the next text's end stalls until it has left.
module cron_expression_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // character
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // minute_mask, hour_mask, dom_mask, month_mask, dow_mask,
    // dom restricted flag, dow restricted flag, zero fill
    output logic [143:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser    // status
);
    import cep_pkg::*;

    cep_cmd_t    cmd;
    cep_sts_t    sts;
    logic        out_status;
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [31:0] dom_mask;
    logic [12:0] month_mask;
    logic [6:0]  dow_mask;
    logic        dom_restr;
    logic        dow_restr;

    cep_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .ready    (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cep_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_char     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (out_status),
        .minute_mask (minute_mask),
        .hour_mask   (hour_mask),
        .dom_mask    (dom_mask),
        .month_mask  (month_mask),
        .dow_mask    (dow_mask),
        .dom_restr   (dom_restr),
        .dow_restr   (dow_restr)
    );

    assign m_axis_tdata = {6'd0, dow_restr, dom_restr, dow_mask, month_mask,
                           dom_mask, hour_mask, minute_mask};
    assign m_axis_tuser = out_status;

endmodule

/* src/cep_ctrl.sv */
// ----------------------------------------------------------------------------
// cep_ctrl
// sequencer of the cron parser: per-beat processing, end of text, result
// ----------------------------------------------------------------------------
`include "cron_expression_parser_core_macros.svh"

module cep_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              ready,
    output cep_pkg::cep_cmd_t cmd,
    input  cep_pkg::cep_sts_t sts
);
    import cep_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                state_next = ST_WAIT_CHAR;
            end
            ST_WAIT_CHAR:
            begin
                if (!sts.exp_busy)
                begin
                    state_next = sts.last ? ST_LAST : ST_IDLE;
                end
            end
            ST_LAST:
            begin
                state_next = ST_WAIT_LAST;
            end
            ST_WAIT_LAST:
            begin
                if (!sts.exp_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready       = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ready    = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHAR:
            begin
                cmd.do_char = 1'b1;
            end
            ST_LAST:
            begin
                cmd.do_last = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !sts.out_busy;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    `CEP_ASSERT_SAME(a_ready_no_expand, ready, !sts.exp_busy)
    `CEP_ASSERT_SAME(a_finish_out_free, cmd.finish, !sts.out_busy)
    `CEP_ASSERT_NEXT(a_expand_needs_cmd, !sts.exp_busy && !(cmd.do_char || cmd.do_last), !sts.exp_busy)

endmodule

/* src/cep_dp.sv */
// ----------------------------------------------------------------------------
// cep_dp
// parser state, range expansion into field masks, and the result register
// ----------------------------------------------------------------------------
module cep_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  cep_pkg::cep_cmd_t cmd,
    output cep_pkg::cep_sts_t sts,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_status,
    output logic [59:0]       minute_mask,
    output logic [23:0]       hour_mask,
    output logic [31:0]       dom_mask,
    output logic [12:0]       month_mask,
    output logic [6:0]        dow_mask,
    output logic              dom_restr,
    output logic              dow_restr
);
    import cep_pkg::*;

    logic [7:0]  char_reg;
    logic        last_reg;

    logic [2:0]  fi_reg,     fi_next;
    phase_t      ph_reg,     ph_next;
    logic [16:0] acc_reg,    acc_next;
    logic [16:0] rs_reg,     rs_next;
    logic [16:0] re_reg,     re_next;
    logic [16:0] step_reg,   step_next;
    name_buf_t   nbuf_reg,   nbuf_next;
    logic [3:0]  nlen_reg,   nlen_next;
    logic [3:0]  pflags_reg, pflags_next;
    logic [1:0]  restr_reg,  restr_next;
    logic        err_reg,    err_next;

    logic        exp_go;
    logic        exp_busy_reg, exp_busy_next;
    logic [6:0]  exp_v_reg,    exp_v_next;
    logic [6:0]  exp_e_reg,    exp_e_next;
    logic [16:0] exp_step_reg, exp_step_next;
    logic [2:0]  exp_k_reg,    exp_k_next;

    logic [59:0] mask_reg  [NUM_FIELDS];
    logic [59:0] mask_next [NUM_FIELDS];

    logic        out_valid_reg;
    logic        out_status_reg;
    logic [59:0] minute_reg;
    logic [23:0] hour_reg;
    logic [31:0] dom_reg;
    logic [12:0] month_reg;
    logic [6:0]  dow_reg;
    logic [1:0]  out_restr_reg;

    // parser step: one beat, or the end of the text
    always_comb
    begin
        logic        end_path;
        logic        fc_en;
        logic        fc_end;
        logic [7:0]  c;
        logic        base_done;
        logic        rdone;
        logic        astep;
        logic        names;
        logic [20:0] pushed;
        logic [4:0]  hit;
        logic [1:0]  cnt;
        logic [16:0] lo;
        logic [16:0] hi;

        fi_next     = fi_reg;
        ph_next     = ph_reg;
        acc_next    = acc_reg;
        rs_next     = rs_reg;
        re_next     = re_reg;
        step_next   = step_reg;
        nbuf_next   = nbuf_reg;
        nlen_next   = nlen_reg;
        pflags_next = pflags_reg;
        restr_next  = restr_reg;
        err_next    = err_reg;
        exp_go      = 1'b0;
        end_path    = 1'b0;
        fc_en       = 1'b0;
        fc_end      = 1'b0;
        base_done   = 1'b0;
        rdone       = 1'b0;
        astep       = 1'b0;
        c           = char_reg;
        names       = (fi_reg >= FLD_MONTH);
        pushed      = 21'(acc_reg) * 21'd10 + 21'(char_reg - 8'h30);
        hit         = name_lookup(nbuf_reg, nlen_reg, fi_reg == FLD_MONTH);
        lo          = 17'(field_lo(fi_reg));
        hi          = 17'(field_hi(fi_reg));
        cnt         = pflags_reg[3:2];

        if (cmd.do_char && !err_reg)
        begin
            if ((c == CH_SPACE) || (c == CH_TAB))
            begin
                end_path = (ph_reg != PH_BETWEEN);
            end
            else if (c == CH_NUL)
            begin
                err_next = 1'b1;
            end
            else
            begin
                if (ph_reg == PH_BETWEEN)
                begin
                    if (fi_reg >= FLD_COUNT)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        ph_next     = PH_BASE;
                        pflags_next = '0;
                        cnt         = 2'd0;
                        if ((c != CH_STAR) && (fi_reg == FLD_DOM))
                        begin
                            restr_next[0] = 1'b1;
                        end
                        if ((c != CH_STAR) && (fi_reg == FLD_DOW))
                        begin
                            restr_next[1] = 1'b1;
                        end
                    end
                end
                // extension screening per comma piece
                if (!err_next)
                begin
                    if ((c == CH_HASH) || (c == CH_AT))
                    begin
                        err_next = 1'b1;
                    end
                    else if (c == CH_COMMA)
                    begin
                        if (pflags_next[0] && (pflags_next[1] || (cnt < 2'd3)))
                        begin
                            err_next = 1'b1;
                        end
                        pflags_next = '0;
                    end
                    else
                    begin
                        if ((c == CH_UP_L) || (c == CH_LO_L) || (c == CH_UP_W) ||
                            (c == CH_LO_W))
                        begin
                            pflags_next[0] = 1'b1;
                        end
                        if (!is_letter(c) && (c != CH_DASH))
                        begin
                            pflags_next[1] = 1'b1;
                        end
                        if (cnt < 2'd3)
                        begin
                            cnt = cnt + 2'd1;
                        end
                        pflags_next[3:2] = cnt;
                    end
                end
                fc_en = !err_next;
            end
        end

        if (cmd.do_last && !err_reg && (ph_reg != PH_BETWEEN))
        begin
            end_path = 1'b1;
        end

        if (end_path)
        begin
            if (pflags_reg[0] && (pflags_reg[1] || (pflags_reg[3:2] < 2'd3)))
            begin
                err_next = 1'b1;
            end
            pflags_next = '0;
            fc_en       = !err_next;
            fc_end      = 1'b1;
            c           = CH_NUL;
        end

        if (fc_en)
        begin
            case (ph_next)
                PH_BASE:
                begin
                    if (c == CH_STAR)
                    begin
                        rs_next = lo;
                        re_next = hi;
                        ph_next = PH_AFTER_BASE;
                    end
                    else if (is_digit(c))
                    begin
                        acc_next = 17'(c - 8'h30);
                        ph_next  = PH_NUM_A;
                    end
                    else if (names && is_letter(c))
                    begin
                        nbuf_next[0] = to_lower(c);
                        nlen_next    = 4'd1;
                        ph_next      = PH_NAME_A;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_NUM_A, PH_NUM_B, PH_STEP:
                begin
                    if (is_digit(c))
                    begin
                        acc_next = pushed[16:0];
                        if (pushed > 21'(NUM_LIMIT))
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (ph_next == PH_NUM_A)
                    begin
                        rs_next   = acc_reg;
                        re_next   = acc_reg;
                        base_done = 1'b1;
                    end
                    else if (ph_next == PH_NUM_B)
                    begin
                        re_next = acc_reg;
                        rdone   = 1'b1;
                    end
                    else
                    begin
                        step_next = acc_reg;
                        if (acc_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            astep = 1'b1;
                        end
                    end
                end
                PH_NAME_A, PH_NAME_B:
                begin
                    if (is_letter(c))
                    begin
                        if (32'(nlen_reg) < NAME_BUF_LEN)
                        begin
                            nbuf_next[nlen_reg] = to_lower(c);
                            nlen_next           = nlen_reg + 4'd1;
                        end
                        else
                        begin
                            nlen_next = 4'(NAME_BUF_LEN + 1);
                        end
                    end
                    else if (!hit[4])
                    begin
                        err_next = 1'b1;
                    end
                    else if (ph_next == PH_NAME_A)
                    begin
                        rs_next   = 17'(hit[3:0]);
                        re_next   = 17'(hit[3:0]);
                        base_done = 1'b1;
                    end
                    else
                    begin
                        re_next = 17'(hit[3:0]);
                        rdone   = 1'b1;
                    end
                end
                PH_AFTER_BASE:
                begin
                    base_done = 1'b1;
                end
                PH_END_START:
                begin
                    if (is_digit(c))
                    begin
                        acc_next = 17'(c - 8'h30);
                        ph_next  = PH_NUM_B;
                    end
                    else if (names && is_letter(c))
                    begin
                        nbuf_next[0] = to_lower(c);
                        nlen_next    = 4'd1;
                        ph_next      = PH_NAME_B;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_STEP_START:
                begin
                    if (is_digit(c))
                    begin
                        acc_next = 17'(c - 8'h30);
                        ph_next  = PH_STEP;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase

            if (base_done)
            begin
                if (!fc_end && (c == CH_DASH))
                begin
                    ph_next = PH_END_START;
                end
                else
                begin
                    rdone = 1'b1;
                end
            end

            if (rdone)
            begin
                if ((rs_next < lo) || (re_next > hi) || (rs_next > re_next))
                begin
                    err_next = 1'b1;
                end
                else if (!fc_end && (c == CH_SLASH))
                begin
                    ph_next = PH_STEP_START;
                end
                else
                begin
                    step_next = 17'd1;
                    astep     = 1'b1;
                end
            end

            if (astep)
            begin
                if (fc_end)
                begin
                    ph_next = PH_BETWEEN;
                    exp_go  = 1'b1;
                end
                else if (c == CH_COMMA)
                begin
                    ph_next = PH_BASE;
                    exp_go  = 1'b1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end

        if (end_path && !err_next)
        begin
            fi_next = fi_reg + 3'd1;
            ph_next = PH_BETWEEN;
        end

        if (cmd.finish)
        begin
            fi_next     = '0;
            ph_next     = PH_BETWEEN;
            acc_next    = '0;
            rs_next     = '0;
            re_next     = '0;
            step_next   = 17'd1;
            nlen_next   = '0;
            pflags_next = '0;
            restr_next  = '0;
            err_next    = 1'b0;
        end
    end

    // range expansion: a whole span when the step is one, else one value a cycle
    always_comb
    begin
        logic [63:0] span;
        logic [63:0] sel;
        logic [17:0] nv;

        exp_busy_next = exp_busy_reg;
        exp_v_next    = exp_v_reg;
        exp_e_next    = exp_e_reg;
        exp_step_next = exp_step_reg;
        exp_k_next    = exp_k_reg;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            mask_next[i] = mask_reg[i];
        end

        span = ({64{1'b1}} << exp_v_reg) & ~({64{1'b1}} << (8'(exp_e_reg) + 8'd1));
        sel  = (exp_step_reg == 17'd1) ? span : (64'd1 << exp_v_reg);
        if ((exp_k_reg == FLD_DOW) && sel[7])
        begin
            sel[7] = 1'b0;
            sel[0] = 1'b1;
        end
        nv = 18'(exp_step_reg) + 18'(exp_v_reg);

        if (exp_go)
        begin
            exp_busy_next = 1'b1;
            exp_v_next    = rs_next[6:0];
            exp_e_next    = re_next[6:0];
            exp_step_next = step_next;
            exp_k_next    = fi_reg;
        end
        else if (exp_busy_reg)
        begin
            mask_next[exp_k_reg] = mask_reg[exp_k_reg] | sel[59:0];
            if ((exp_step_reg == 17'd1) || (nv > 18'(exp_e_reg)))
            begin
                exp_busy_next = 1'b0;
            end
            else
            begin
                exp_v_next = nv[6:0];
            end
        end

        if (cmd.finish)
        begin
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                mask_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg        <= '0;
            ph_reg        <= PH_BETWEEN;
            acc_reg       <= '0;
            rs_reg        <= '0;
            re_reg        <= '0;
            step_reg      <= 17'd1;
            nlen_reg      <= '0;
            pflags_reg    <= '0;
            restr_reg     <= '0;
            err_reg       <= 1'b0;
            exp_busy_reg  <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else
        begin
            fi_reg       <= fi_next;
            ph_reg       <= ph_next;
            acc_reg      <= acc_next;
            rs_reg       <= rs_next;
            re_reg       <= re_next;
            step_reg     <= step_next;
            nlen_reg     <= nlen_next;
            pflags_reg   <= pflags_next;
            restr_reg    <= restr_next;
            err_reg      <= err_next;
            exp_busy_reg <= exp_busy_next;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                mask_reg[i] <= mask_next[i];
            end
            if (cmd.load)
            begin
                last_reg <= in_last;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nbuf_reg     <= nbuf_next;
        exp_v_reg    <= exp_v_next;
        exp_e_reg    <= exp_e_next;
        exp_step_reg <= exp_step_next;
        exp_k_reg    <= exp_k_next;
        if (cmd.load)
        begin
            char_reg <= in_char;
        end
        if (cmd.finish)
        begin
            // any error or a wrong field count blanks the whole result
            out_status_reg <= err_reg || (fi_reg != FLD_COUNT);
            if (err_reg || (fi_reg != FLD_COUNT))
            begin
                minute_reg    <= '0;
                hour_reg      <= '0;
                dom_reg       <= '0;
                month_reg     <= '0;
                dow_reg       <= '0;
                out_restr_reg <= '0;
            end
            else
            begin
                minute_reg    <= mask_reg[0];
                hour_reg      <= mask_reg[1][23:0];
                dom_reg       <= mask_reg[2][31:0];
                month_reg     <= mask_reg[3][12:0];
                dow_reg       <= mask_reg[4][6:0];
                out_restr_reg <= restr_reg;
            end
        end
    end

    assign sts.exp_busy = exp_busy_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign sts.last     = last_reg;

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign minute_mask = minute_reg;
    assign hour_mask   = hour_reg;
    assign dom_mask    = dom_reg;
    assign month_mask  = month_reg;
    assign dow_mask    = dow_reg;
    assign dom_restr   = out_restr_reg[0];
    assign dow_restr   = out_restr_reg[1];

endmodule
